### rtl/core/bfid_pkg.sv
`timescale 1ns / 1ps

package bfid_pkg;

  // Sizes of the block.
  localparam int TGT_SIDE = 256;
  localparam int SRC_SIDE = 4096;
  localparam int COL_W    = $clog2(TGT_SIDE);
  localparam int POS_W    = $clog2(SRC_SIDE);
  localparam int SIDE_W   = 13;
  localparam int MS_W     = 9;
  localparam int SUM_W    = 32;
  localparam int MEAN_W   = 16;
  localparam int CNT_W    = 2 * POS_W + 1;
  localparam int ACC_W    = 22;
  localparam int LANES    = 3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SRC_W  = 2'd0;
  localparam logic [1:0] REG_SRC_H  = 2'd1;
  localparam logic [1:0] REG_MAX_SZ = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_RMW  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  // Request to the mean divider.
  typedef struct packed {
    logic                         start;
    logic [CNT_W-1:0]             count;
    logic [LANES-1:0][SUM_W-1:0]  sum;
  } div_req_t;

  // Answer of the mean divider.
  typedef struct packed {
    logic                         done;
    logic [LANES-1:0][MEAN_W-1:0] mean;
  } div_rsp_t;

endpackage

### rtl/core/box_filter_image_downscale.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in_      slave      tvalid / tready     tdata: red, green, blue (8 bits each)
// out_     master     tvalid / tready     tdata: col, row, three 8.8 means; tlast
// cfg_     APB slave  psel / penable      source_width, source_height, max_size
//
// Each pixel has its column sums read from the sum memory in S_IDLE, then the
// add and write back in S_RMW on the same memory port pair.
// A pixel that completes a box then needs a rounding pass and sixteen quotient
// steps in the mean divider, which runs one bit per cycle, and a load into the
// output register once that register is free.
// Reset and any write to a known register set up the box walkers in S_INIT.
// Pixels keep flowing while a finished texel waits in the output register;
// a second finished box waits in the divider until the first is taken.
module box_filter_image_downscale import bfid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] red_byte, [15:8] green_byte, [23:16] blue_byte
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] target_col, [15:8] target_row, [31:16] red_mean,
  // [47:32] green_mean, [63:48] blue_mean
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  state_t state_r, state_nxt;

  logic [SIDE_W-1:0] sw_r, sh_r;
  logic [MS_W-1:0]   ms_r;
  logic              cfg_wr, cfg_restart;

  logic [SIDE_W-1:0] sw_c, sh_c, tw, th;
  logic [MS_W-1:0]   ms_c;

  logic [POS_W-1:0]  col_pos_r, row_pos_r, rl_r, rh_r;
  logic [COL_W-1:0]  bc_r, br_r;
  logic [ACC_W-1:0]  a_r, b_r, c_r, d_r;
  logic              col_end, row_end, accept;

  logic [LANES-1:0][7:0]       pix_r;
  logic [COL_W-1:0]            addr_r, row_q_r;
  logic                        box_end_r, last_q_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [TGT_SIDE-1:0]         vld_r;
  logic [LANES*SUM_W-1:0]      rdata, wdata;
  logic [LANES-1:0][SUM_W-1:0] sums;
  logic                        we;

  div_req_t dreq;
  div_rsp_t drsp;
  logic     out_load;

  logic [COL_W-1:0]             out_col_r, out_row_r;
  logic [LANES-1:0][MEAN_W-1:0] out_mean_r;
  logic                         out_last_r, out_valid_r;
  logic [COL_W-1:0]             div_col_r, div_row_r;
  logic                         div_last_r;

  // Configuration registers.
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // Only a write to a known register abandons the image in progress.
  assign cfg_restart = cfg_wr && ((cfg_paddr[3:2] == REG_SRC_W) ||
                                  (cfg_paddr[3:2] == REG_SRC_H) ||
                                  (cfg_paddr[3:2] == REG_MAX_SZ));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SIDE_W'(1);
      sh_r <= SIDE_W'(1);
      ms_r <= MS_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SRC_W:  sw_r <= cfg_pwdata[SIDE_W-1:0];
        REG_SRC_H:  sh_r <= cfg_pwdata[SIDE_W-1:0];
        REG_MAX_SZ: ms_r <= cfg_pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SRC_W:  cfg_prdata = 32'(sw_r);
      REG_SRC_H:  cfg_prdata = 32'(sh_r);
      REG_MAX_SZ: cfg_prdata = 32'(ms_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Effective sides after clamping.
  always_comb begin
    sw_c = (sw_r == '0) ? SIDE_W'(1) : (sw_r > SIDE_W'(SRC_SIDE)) ? SIDE_W'(SRC_SIDE) : sw_r;
    sh_c = (sh_r == '0) ? SIDE_W'(1) : (sh_r > SIDE_W'(SRC_SIDE)) ? SIDE_W'(SRC_SIDE) : sh_r;
    ms_c = (ms_r == '0) ? MS_W'(1) : (ms_r > MS_W'(TGT_SIDE)) ? MS_W'(TGT_SIDE) : ms_r;
    tw   = (sw_c < SIDE_W'(ms_c)) ? sw_c : SIDE_W'(ms_c);
    th   = (sh_c < SIDE_W'(ms_c)) ? sh_c : SIDE_W'(ms_c);
  end

  // A box edge is reached when (pos + 2) * t exceeds (index + 1) * s.
  assign col_end   = a_r > b_r;
  assign row_end   = c_r > d_r;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_RMW;
      S_RMW:   state_nxt = box_end_r ? S_DIV : S_IDLE;
      S_DIV:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
    if (cfg_restart) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Box walkers for columns and rows.
  always_ff @(posedge clk) begin
    if (!rst_n || state_r == S_INIT) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      rl_r      <= '0;
      rh_r      <= '0;
      bc_r      <= '0;
      br_r      <= '0;
      a_r       <= ACC_W'({tw, 1'b0});
      b_r       <= ACC_W'(sw_c);
      c_r       <= ACC_W'({th, 1'b0});
      d_r       <= ACC_W'(sh_c);
    end else if (accept) begin
      if (!col_end) begin
        col_pos_r <= col_pos_r + 1'b1;
        a_r       <= a_r + ACC_W'(tw);
        rl_r      <= rl_r + 1'b1;
      end else if (SIDE_W'(col_pos_r) + 1'b1 < sw_c) begin
        col_pos_r <= col_pos_r + 1'b1;
        a_r       <= a_r + ACC_W'(tw);
        bc_r      <= bc_r + 1'b1;
        b_r       <= b_r + ACC_W'(sw_c);
        rl_r      <= '0;
      end else begin
        col_pos_r <= '0;
        a_r       <= ACC_W'({tw, 1'b0});
        bc_r      <= '0;
        b_r       <= ACC_W'(sw_c);
        rl_r      <= '0;
        if (!row_end) begin
          row_pos_r <= row_pos_r + 1'b1;
          c_r       <= c_r + ACC_W'(th);
          rh_r      <= rh_r + 1'b1;
        end else if (SIDE_W'(row_pos_r) + 1'b1 < sh_c) begin
          row_pos_r <= row_pos_r + 1'b1;
          c_r       <= c_r + ACC_W'(th);
          br_r      <= br_r + 1'b1;
          d_r       <= d_r + ACC_W'(sh_c);
          rh_r      <= '0;
        end else begin
          row_pos_r <= '0;
          c_r       <= ACC_W'({th, 1'b0});
          br_r      <= '0;
          d_r       <= ACC_W'(sh_c);
          rh_r      <= '0;
        end
      end
    end
  end

  // Capture of the accepted pixel and its box.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r     <= in_tdata;
      addr_r    <= bc_r;
      row_q_r   <= br_r;
      box_end_r <= col_end && row_end;
      last_q_r  <= (SIDE_W'(bc_r) + 1'b1 >= tw) && (SIDE_W'(br_r) + 1'b1 >= th);
      cnt_r     <= CNT_W'(({1'b0, rl_r} + 1'b1) * ({1'b0, rh_r} + 1'b1));
    end
  end

  // Column sum memory: read on accept, add and write back in S_RMW.
  bfid_ram #(
    .WIDTH (LANES * SUM_W),
    .DEPTH (TGT_SIDE)
  ) u_sums (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (bc_r),
    .rdata (rdata)
  );

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sums[i] = (vld_r[addr_r] ? rdata[i*SUM_W +: SUM_W] : '0) + SUM_W'(pix_r[i]);
    end
    we    = (state_r == S_RMW);
    wdata = box_end_r ? '0 : sums;
  end

  // Entries not written since the last restart read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  // Mean divider.
  assign dreq.start = we && box_end_r;
  assign dreq.count = cnt_r;
  assign dreq.sum   = sums;

  bfid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_ff @(posedge clk) begin
    if (dreq.start) begin
      div_col_r  <= addr_r;
      div_row_r  <= row_q_r;
      div_last_r <= last_q_r;
    end
  end

  // Output register.
  assign out_load = (state_r == S_DIV) && drsp.done && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col_r  <= div_col_r;
      out_row_r  <= div_row_r;
      out_mean_r <= drsp.mean;
      out_last_r <= div_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mean_r[2], out_mean_r[1], out_mean_r[0], out_row_r, out_col_r};
  assign out_tlast  = out_last_r;

  // Checks.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |=> state_r == S_DIV || state_r == S_INIT)
    else $error("divider started outside a box end");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> drsp.done) else $error("texel loaded before divider finished");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DIV))
    else $error("texel appeared without a divide");

endmodule

### rtl/core/bfid_ram.sv
`timescale 1ns / 1ps

module bfid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bfid_div.sv
`timescale 1ns / 1ps

module bfid_div import bfid_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NUM_W = SUM_W + 9;

  logic                        busy_r, pre_r, done_r;
  logic [3:0]                  step_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [LANES-1:0][SUM_W-1:0] sum_r;
  logic [LANES-1:0][CNT_W-1:0] rem_r;
  logic [LANES-1:0][15:0]      low_r;
  logic [LANES-1:0][15:0]      q_r;

  // Control: a rounding pass, then sixteen restoring steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pre_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      pre_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (pre_r) begin
      pre_r  <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 4'd1;
      if (step_r == 4'd15) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Data path of the three lanes, which share the pixel count.
  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] num;
    logic [CNT_W:0]   trial;
    if (req.start) begin
      sum_r <= req.sum;
      cnt_r <= req.count;
    end else if (pre_r) begin
      for (int i = 0; i < LANES; i++) begin
        num = {1'b0, sum_r[i], 8'd0} + NUM_W'(cnt_r >> 1);
        rem_r[i] <= num[NUM_W-1:16];
        low_r[i] <= num[15:0];
      end
    end else if (busy_r) begin
      for (int i = 0; i < LANES; i++) begin
        trial = {rem_r[i], low_r[i][15]};
        if (trial >= {1'b0, cnt_r}) begin
          rem_r[i] <= CNT_W'(trial - {1'b0, cnt_r});
          q_r[i]   <= {q_r[i][14:0], 1'b1};
        end else begin
          rem_r[i] <= trial[CNT_W-1:0];
          q_r[i]   <= {q_r[i][14:0], 1'b0};
        end
        low_r[i] <= {low_r[i][14:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.mean = q_r;

endmodule
